[src/utcl_pkg.sv]
// Shared types, register indexes and calendar helpers for the UTC to local time block.
package utcl_pkg;

    localparam int unsigned CFG_INDEX_W = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_OFFSET_HOURS    = 2'd0;
    localparam cfg_index_t CFG_OFFSET_NEGATIVE = 2'd1;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [6:0] HOURS_PER_DAY = 7'd24;
    localparam logic [6:0] YEAR_LAST     = 7'd99;
    localparam logic [6:0] YEARS_PER_CENTURY = 7'd100;

    typedef struct packed {
        logic [6:0] utc_year;
        logic [3:0] utc_month;
        logic [4:0] utc_day;
        logic [4:0] utc_hour;
        logic [5:0] utc_minute;
        logic [5:0] utc_second;
    } utc_word_t;

    typedef struct packed {
        logic [6:0] local_year;
        logic [3:0] local_month;
        logic [4:0] local_day;
        logic [4:0] local_hour;
        logic [5:0] local_minute;
        logic [5:0] local_second;
    } local_word_t;

    typedef struct packed {
        logic [4:0] offset_hours;
        logic       offset_negative;
    } utcl_cfg_t;

    // Days in a month; February is 29 in a leap year.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            if (month == MONTH_FEB)
            begin
                len = leap ? 5'd29 : 5'd28;
            end
            else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV)
            begin
                len = 5'd30;
            end
            else
            begin
                len = 5'd31;
            end
            return len;
        end
    endfunction

endpackage

[src/utcl_calc.sv]
// Combinational hour offset and date rollover for one time stamp.
module utcl_calc
    import utcl_pkg::*;
(
    input  utc_word_t   utc,
    input  utcl_cfg_t   cfg,
    output local_word_t local_time
);

    logic [5:0] sum;
    logic       carry;
    logic [5:0] add_hour;
    logic [6:0] diff;
    logic [6:0] sub_hour;
    logic       borrow;
    logic [6:0] year_mod;
    logic [6:0] year_inc;
    logic [6:0] year_dec;
    logic       leap;
    logic       month_ok;
    logic [5:0] add_day;
    logic [4:0] cur_len;
    logic [3:0] prev_month;
    logic [5:0] back_day;

    always_comb
    begin
        sum      = {1'b0, utc.utc_hour} + {1'b0, cfg.offset_hours};
        carry    = (sum >= HOURS_PER_DAY[5:0]);
        if (sum >= 6'd48)
            add_hour = sum - 6'd48;
        else if (carry)
            add_hour = sum - HOURS_PER_DAY[5:0];
        else
            add_hour = sum;

        diff = {2'b00, utc.utc_hour} + 7'd48 - {2'b00, cfg.offset_hours};
        if (diff >= 7'd72)
            sub_hour = diff - 7'd72;
        else if (diff >= 7'd48)
            sub_hour = diff - 7'd48;
        else if (diff >= HOURS_PER_DAY)
            sub_hour = diff - HOURS_PER_DAY;
        else
            sub_hour = diff;
        borrow = (utc.utc_hour < cfg.offset_hours);

        year_mod = (utc.utc_year >= YEARS_PER_CENTURY) ? utc.utc_year - YEARS_PER_CENTURY
                                                       : utc.utc_year;
        year_inc = (year_mod == YEAR_LAST) ? 7'd0 : year_mod + 7'd1;
        year_dec = (year_mod == 7'd0) ? YEAR_LAST : year_mod - 7'd1;
        // leap test on the year as given
        leap     = (utc.utc_year[1:0] == 2'b00);
        month_ok = (utc.utc_month >= MONTH_JAN) && (utc.utc_month <= MONTH_DEC);

        add_day    = {1'b0, utc.utc_day} + {5'd0, carry};
        cur_len    = month_len(utc.utc_month, leap);
        prev_month = (utc.utc_month == MONTH_JAN) ? MONTH_DEC : utc.utc_month - 4'd1;
        back_day   = {1'b0, utc.utc_day} + {1'b0, month_len(prev_month, leap)}
                     - {5'd0, borrow};

        local_time.local_year   = utc.utc_year;
        local_time.local_month  = utc.utc_month;
        local_time.local_minute = utc.utc_minute;
        local_time.local_second = utc.utc_second;

        if (!cfg.offset_negative)
        begin
            local_time.local_hour = add_hour[4:0];
            local_time.local_day  = add_day[4:0];
            if (month_ok && add_day > {1'b0, cur_len})
            begin
                local_time.local_day = add_day[4:0] - cur_len;
                if (utc.utc_month == MONTH_DEC)
                begin
                    local_time.local_month = MONTH_JAN;
                    local_time.local_year  = year_inc;
                end
                else
                begin
                    local_time.local_month = utc.utc_month + 4'd1;
                end
            end
        end
        else
        begin
            local_time.local_hour = sub_hour[4:0];
            // invalid month also lands here: 5-bit wrap of day - borrow
            local_time.local_day  = utc.utc_day - {4'd0, borrow};
            if (month_ok && ({1'b0, utc.utc_day} < 6'd1 + {5'd0, borrow}))
            begin
                local_time.local_day   = back_day[4:0];
                local_time.local_month = prev_month;
                if (utc.utc_month == MONTH_JAN)
                begin
                    local_time.local_year = year_dec;
                end
            end
        end
    end

endmodule

[src/utc_to_local_time_offset.sv]
// Top level: UTC time stamp to local time with a configured whole-hour offset.
//
//  channel   dir   handshake              payload
//  in        in    in_valid / in_stall    in_data  (utc_word_t)
//  out       out   out_valid / out_stall  out_data (local_word_t)
//  cfg       in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low. A word passes an input
// register, the date logic and the output register, which drives out_valid.
// in_stall rises only when both registers are full and out_stall is high;
// an empty input register is always refilled, so bubbles collapse.
// Reset clears the valid bits and the offset registers (offset zero, add).
// cfg_ready is always high; writes are expected while the block is idle.
module utc_to_local_time_offset
    import utcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  utc_word_t   in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output local_word_t out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [4:0]  cfg_data
);

    utcl_cfg_t   cfg_reg;
    logic        s1_valid_reg;
    utc_word_t   s1_data_reg;
    logic        s2_valid_reg;
    local_word_t s2_data_reg;
    local_word_t calc_out;
    logic        s2_load;
    logic        s1_load;

    assign cfg_ready = 1'b1;

    // Offset registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_OFFSET_HOURS)
                cfg_reg.offset_hours <= cfg_data;
            else if (cfg_index == CFG_OFFSET_NEGATIVE)
                cfg_reg.offset_negative <= cfg_data[0];
        end
    end

    // Output register frees when empty or taken this cycle.
    assign s2_load  = !s2_valid_reg || !out_stall;
    // Input register takes a word when empty or moving on.
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= in_valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
            s1_data_reg <= in_data;
        if (s2_load && s1_valid_reg)
            s2_data_reg <= calc_out;
    end

    utcl_calc u_calc
    (
        .utc        (s1_data_reg),
        .cfg        (cfg_reg),
        .local_time (calc_out)
    );

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // Backpressure reaches the input only with both stages full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid && out_stall))
        else $error("input stalled with a free stage");

    // An accepted word occupies the input register next cycle.
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted word lost");

    // Delivered hour is always reduced to a day.
    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.local_hour < 5'd24))
        else $error("local hour out of range");

    // A buffered word moves to the output when the output frees.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (!out_valid || !out_stall)) |=> out_valid)
        else $error("word did not advance");

endmodule
